[rtl/core/spq_pkg.sv]
// Shared types and codes for the sorted priority queue.
package spq_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned CNT_OUT_W = 7;
  localparam int unsigned IN_TDATA_W = 72;
  localparam int unsigned OUT_TDATA_W = 80;

  localparam logic [1:0] OP_ENQ  = 2'd0;
  localparam logic [1:0] OP_DEQ  = 2'd1;
  localparam logic [1:0] OP_PEEK = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    logic signed [DATA_W-1:0] prio;
  } entry_t;

  typedef struct packed {
    logic enq;
    logic deq;
  } cell_ctrl_t;

endpackage

[rtl/core/spq_cell.sv]
// One slot of the sorted row: compares the broadcast entry and shifts with its neighbors.
module spq_cell (
  input  logic               clk,
  input  spq_pkg::cell_ctrl_t ctrl_i,
  input  logic               occ_i,
  input  spq_pkg::entry_t    new_i,
  input  spq_pkg::entry_t    left_i,
  input  logic               left_ahead_i,
  input  spq_pkg::entry_t    right_i,
  output logic               ahead_o,
  output spq_pkg::entry_t    ent_o,
  output spq_pkg::entry_t    ent_nxt_o
);

  spq_pkg::entry_t ent_r;
  spq_pkg::entry_t ent_nxt;

  // new entry belongs ahead of this slot (an empty slot always takes it)
  assign ahead_o = !occ_i ||
                   (new_i.prio > ent_r.prio) ||
                   ((new_i.prio == ent_r.prio) && (ent_r.data < new_i.data));

  always_comb begin
    ent_nxt = ent_r;
    if (ctrl_i.enq) begin
      if (left_ahead_i) begin
        ent_nxt = left_i;
      end else if (ahead_o) begin
        ent_nxt = new_i;
      end
    end else if (ctrl_i.deq) begin
      ent_nxt = right_i;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  assign ent_o     = ent_r;
  assign ent_nxt_o = ent_nxt;

endmodule

[rtl/core/sorted_priority_queue_unit.sv]
// Top level: sorted priority queue built from a row of compare-and-shift cells.
//
//   channel  dir  handshake              payload
//   in_      in   in_tvalid/in_tready    opcode, item_data, item_priority
//   out_     out  out_tvalid/out_tready  head_data, head_priority, queue_empty,
//                                        entry_count, status
//
// One word per cycle unless the output stalls: every cell compares against the
// broadcast entry and shifts in the same cycle, the result lands in the output
// register next edge. The output register holds a result while out_tready is
// low, and a new word is taken in the cycle that result is taken.
// Reset clears the fill count and the output valid; slot contents are not reset.
module sorted_priority_queue_unit #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [1:0] opcode, [33:2] item_data, [65:34] item_priority, [71:66] zero
  input  logic [spq_pkg::IN_TDATA_W-1:0]    in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [31:0] head_data, [63:32] head_priority, [64] queue_empty,
  // [71:65] entry_count, [73:72] status, [79:74] zero
  output logic [spq_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  localparam int unsigned CW = ($clog2(DEPTH + 1) > spq_pkg::CNT_OUT_W) ?
                               $clog2(DEPTH + 1) : spq_pkg::CNT_OUT_W;

  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;
  logic          out_valid_r;
  logic [spq_pkg::OUT_TDATA_W-1:0] out_data_r;

  logic [1:0]            opcode;
  spq_pkg::entry_t       new_ent;
  spq_pkg::cell_ctrl_t   ctrl;
  logic [1:0]            status;
  logic                  in_fire;
  logic                  full;
  logic                  empty;

  logic            [DEPTH-1:0] ahead;
  spq_pkg::entry_t             ent     [DEPTH];
  spq_pkg::entry_t             ent_nxt [DEPTH];

  assign opcode       = in_tdata[1:0];
  assign new_ent.data = in_tdata[33:2];
  assign new_ent.prio = in_tdata[65:34];

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign full      = (count_r == CW'(DEPTH));
  assign empty     = (count_r == '0);

  always_comb begin
    ctrl      = '0;
    status    = spq_pkg::ST_OK;
    count_nxt = count_r;
    unique case (opcode)
      spq_pkg::OP_ENQ: begin
        if (full) begin
          status = spq_pkg::ST_FULL;
        end else begin
          ctrl.enq  = in_fire;
          count_nxt = count_r + 1'b1;
        end
      end
      spq_pkg::OP_DEQ: begin
        if (empty) begin
          status = spq_pkg::ST_EMPTY;
        end else begin
          ctrl.deq  = in_fire;
          count_nxt = count_r - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    spq_pkg::entry_t left_ent;
    spq_pkg::entry_t right_ent;
    logic            left_ahead;

    if (i == 0) begin : g_first
      assign left_ent   = new_ent;
      assign left_ahead = 1'b0;
    end else begin : g_mid
      assign left_ent   = ent[i-1];
      assign left_ahead = ahead[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_ent = ent[i];
    end else begin : g_inner
      assign right_ent = ent[i+1];
    end

    spq_cell u_cell (
      .clk          (clk),
      .ctrl_i       (ctrl),
      .occ_i        (count_r > CW'(i)),
      .new_i        (new_ent),
      .left_i       (left_ent),
      .left_ahead_i (left_ahead),
      .right_i      (right_ent),
      .ahead_o      (ahead[i]),
      .ent_o        (ent[i]),
      .ent_nxt_o    (ent_nxt[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r[79:74] <= '0;
      out_data_r[73:72] <= status;
      out_data_r[71:65] <= count_nxt[spq_pkg::CNT_OUT_W-1:0];
      if (count_nxt == '0) begin
        out_data_r[64]    <= 1'b1;
        out_data_r[63:0]  <= '0;
      end else begin
        out_data_r[64]    <= 1'b0;
        out_data_r[63:32] <= ent_nxt[0].prio;
        out_data_r[31:0]  <= ent_nxt[0].data;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

[tb/sv/tb.sv]
// Testbench for sorted_priority_queue_unit: stream driver, monitor and checker.
`timescale 1ns / 100ps

module tb;

  localparam int unsigned DEPTH = 64;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] data;
    logic [31:0] prio;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] head_data;
    logic signed [31:0] head_prio;
    logic               empty;
    logic [6:0]         count;
    logic [1:0]         status;
  } head_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [79:0] out_tdata;

  sorted_priority_queue_unit #(.DEPTH(DEPTH)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata)
  );

  always #6 clk = ~clk;

  cmd_t  cmd_fifo[$];
  head_t head_fifo[$];
  spq_pkg::entry_t slots[DEPTH];
  int unsigned fill_cnt = 0;
  int unsigned gen_fill = 0;
  bit          filling = 1'b1;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          in_took = 1'b0;
  int unsigned errors = 0;
  int unsigned words_in = 0;
  int unsigned full_rejects = 0;
  int unsigned empty_rejects = 0;
  int unsigned peak_fill = 0;

  function automatic head_t queue_op(logic [1:0] op, logic signed [31:0] d,
                                     logic signed [31:0] p);
    head_t r;
    int unsigned pos;
    r.status = spq_pkg::ST_OK;
    if (op == spq_pkg::OP_ENQ) begin
      if (fill_cnt >= DEPTH) begin
        r.status = spq_pkg::ST_FULL;
        full_rejects++;
      end else begin
        pos = fill_cnt;
        while (pos > 0 && (p > slots[pos-1].prio ||
                           (p == slots[pos-1].prio && slots[pos-1].data < d))) begin
          slots[pos] = slots[pos-1];
          pos--;
        end
        slots[pos].data = d;
        slots[pos].prio = p;
        fill_cnt++;
      end
    end else if (op == spq_pkg::OP_DEQ) begin
      if (fill_cnt == 0) begin
        r.status = spq_pkg::ST_EMPTY;
        empty_rejects++;
      end else begin
        for (int i = 0; i + 1 < fill_cnt; i++) slots[i] = slots[i+1];
        fill_cnt--;
      end
    end
    if (fill_cnt > peak_fill) peak_fill = fill_cnt;
    r.empty = (fill_cnt == 0);
    r.head_data = r.empty ? '0 : slots[0].data;
    r.head_prio = r.empty ? '0 : slots[0].prio;
    r.count = fill_cnt[6:0];
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%08h, got 0x%08h", name, want, got);
      errors++;
    end
  endtask

  // driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_took) begin
      if (cmd_fifo.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        cmd_t c;
        c = cmd_fifo.pop_front();
        in_tdata <= {6'b0, c.prio, c.data, c.op};
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
    out_tready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
  end

  // monitor
  always @(posedge clk) begin
    head_t got;
    head_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.head_data = out_tdata[31:0];
      got.head_prio = out_tdata[63:32];
      got.empty = out_tdata[64];
      got.count = out_tdata[71:65];
      got.status = out_tdata[73:72];
      if (head_fifo.size() == 0) begin
        $error("result word with no expected result pending");
        errors++;
      end else begin
        want = head_fifo.pop_front();
        check_field("head_data", want.head_data, got.head_data);
        check_field("head_priority", want.head_prio, got.head_prio);
        check_field("queue_empty", 32'(want.empty), 32'(got.empty));
        check_field("entry_count", 32'(want.count), 32'(got.count));
        check_field("status", 32'(want.status), 32'(got.status));
      end
    end
    if (rst_n && in_tvalid && in_tready) begin
      head_fifo.push_back(queue_op(in_tdata[1:0], in_tdata[33:2], in_tdata[65:34]));
      words_in++;
    end
    in_took <= rst_n && in_tvalid && in_tready;
  end

  task automatic push_cmd(logic [1:0] op, logic [31:0] d, logic [31:0] p);
    cmd_t c;
    c.op = op;
    c.data = d;
    c.prio = p;
    cmd_fifo.push_back(c);
    if (op == spq_pkg::OP_ENQ && gen_fill < DEPTH) gen_fill++;
    else if (op == spq_pkg::OP_DEQ && gen_fill > 0) gen_fill--;
  endtask

  function automatic logic [31:0] pick_extreme();
    case ($urandom_range(3))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      default: return 32'hffff_ffff;
    endcase
  endfunction

  // Sweeps full -> empty -> full; small value ranges force ties.
  task automatic push_random(int unsigned n);
    int unsigned r;
    logic [1:0]  op;
    logic [31:0] d;
    logic [31:0] p;
    for (int unsigned i = 0; i < n; i++) begin
      if (gen_fill == DEPTH) filling = 1'b0;
      if (gen_fill == 0) filling = 1'b1;
      r = $urandom_range(99);
      if (r < 4) op = OP_UNUSED;
      else if (r < 12) op = spq_pkg::OP_PEEK;
      else op = ($urandom_range(99) < (filling ? 78 : 22)) ? spq_pkg::OP_ENQ :
                                                              spq_pkg::OP_DEQ;
      case ($urandom_range(3))
        0: begin
          d = $urandom;
          p = $urandom;
        end
        1: begin
          d = $urandom_range(4) - 2;
          p = $urandom_range(6) - 3;
        end
        2: begin
          d = $urandom;
          p = $urandom_range(3) - 1;
        end
        default: begin
          d = pick_extreme();
          p = pick_extreme();
        end
      endcase
      push_cmd(op, d, p);
    end
  endtask

  task automatic wait_drained();
    while (cmd_fifo.size() != 0 || in_tvalid || head_fifo.size() != 0) @(posedge clk);
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    push_cmd(spq_pkg::OP_PEEK, $urandom, $urandom);
    push_cmd(spq_pkg::OP_DEQ, $urandom, $urandom);
    push_cmd(OP_UNUSED, $urandom, $urandom);
    push_cmd(spq_pkg::OP_ENQ, 32'h8000_0000, 32'h7fff_ffff);
    push_cmd(spq_pkg::OP_ENQ, 32'h7fff_ffff, 32'h7fff_ffff);
    push_cmd(spq_pkg::OP_ENQ, 32'h7fff_ffff, 32'h7fff_ffff);
    push_cmd(spq_pkg::OP_ENQ, 32'h0000_0000, 32'h8000_0000);
    push_cmd(spq_pkg::OP_ENQ, 32'hffff_ffff, 32'h0000_0000);
    push_cmd(spq_pkg::OP_ENQ, 32'h0000_0005, 32'hffff_ffff);
    push_cmd(spq_pkg::OP_ENQ, 32'h0000_0004, 32'hffff_ffff);
    push_cmd(spq_pkg::OP_ENQ, 32'h8000_0000, 32'h8000_0000);
    push_cmd(spq_pkg::OP_PEEK, $urandom, $urandom);
    push_cmd(OP_UNUSED, $urandom, $urandom);
    for (int i = 0; i < 8; i++) push_cmd(spq_pkg::OP_DEQ, $urandom, $urandom);
    push_cmd(spq_pkg::OP_DEQ, $urandom, $urandom);
    push_cmd(spq_pkg::OP_PEEK, $urandom, $urandom);
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
        default: begin send_idle_pct = 22; recv_stall_pct = 22; end
      endcase
      push_random(482);
      wait_drained();
    end

    repeat (8) @(posedge clk);
    $display("Sent %0d words over four idle/stall phases; %0d full and %0d empty rejects.",
             words_in, full_rejects, empty_rejects);
    $display("Peak queue fill %0d of %0d entries.", peak_fill, DEPTH);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Timeout waiting for the queue to drain.");
    $display("DONE: errors detected");
    $finish;
  end

endmodule

[filelist.f]
rtl/core/spq_pkg.sv
rtl/core/spq_cell.sv
rtl/core/sorted_priority_queue_unit.sv
tb/sv/tb.sv
